[rtl/gbns_pkg.sv]
`timescale 1ns / 1ps

package gbns_pkg;

   localparam int WINDOW_DEF   = 4;
   localparam int SEQ_BITS_DEF = 8;
   localparam int TIMEOUT_W    = 16;

   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd2;

   localparam logic [1:0] OP_TICK    = 2'd0;
   localparam logic [1:0] OP_ACK     = 2'd1;
   localparam logic [1:0] OP_PAYLOAD = 2'd2;

   typedef struct packed {
      logic [1:0] opcode;
      logic [7:0] ack_seq;
      logic [7:0] payload;
   } req_type;

   typedef struct packed {
      logic       send_valid;
      logic [7:0] send_seq;
      logic [7:0] send_byte;
      logic       is_resend;
      logic       accepted;
      logic [4:0] in_flight;
      logic       last;
   } rsp_type;

endpackage

[rtl/go_back_n_sender_window_core.sv]
`timescale 1ns / 1ps

// Channel     Handshake                    Payload
// request     start, busy (taken: !busy)   req_data  (gbns_pkg::req_type)
// response    rsp_valid strobe             rsp_data  (gbns_pkg::rsp_type)
// csr         csr_valid, csr_ready         csr_data  (timeout_ticks, 16 bits)
//
// A payload, an ack outside the window, a tick with nothing to resend and opcode 3
// each give one result in the cycle after start; busy stays low.
// An accepted ack releases one entry per cycle as the base slides, then gives one result.
// An expiring tick with unacked entries examines one slot per cycle from the base up to
// the last unacked one, giving one resend per unacked entry.
// Reset empties the window, clears the idle count and sets the timeout to 2.
module go_back_n_sender_window_core #(
   parameter int WINDOW   = gbns_pkg::WINDOW_DEF,
   parameter int SEQ_BITS = gbns_pkg::SEQ_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  gbns_pkg::req_type              req_data,
   output logic                           busy,
   output logic                           rsp_valid,
   output gbns_pkg::rsp_type              rsp_data,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [gbns_pkg::TIMEOUT_W-1:0] csr_data
);

   localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int CNT_W = $clog2(WINDOW + 1);
   localparam int TW    = gbns_pkg::TIMEOUT_W;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SLIDE  = 2'd1;
   localparam logic [1:0] ST_RESEND = 2'd2;

   logic [1:0]          state_ff,   state_in;
   logic [SEQ_BITS-1:0] base_ff,    base_in;
   logic [IDX_W-1:0]    head_ff,    head_in;
   logic [CNT_W-1:0]    cnt_ff,     cnt_in;
   logic [CNT_W-1:0]    ackc_ff,    ackc_in;
   logic [WINDOW-1:0]   mark_ff,    mark_in;
   logic [TW-1:0]       idle_ff,    idle_in;
   logic [TW-1:0]       timeout_ff;
   logic [IDX_W-1:0]    ptr_ff,     ptr_in;
   logic [CNT_W-1:0]    off_ff,     off_in;
   logic [CNT_W-1:0]    rem_ff,     rem_in;
   logic                rsp_valid_ff, rsp_valid_in;
   gbns_pkg::rsp_type   rsp_ff,     rsp_in;
   logic [7:0]          pay_ff [WINDOW];

   logic                pay_we;
   logic [IDX_W-1:0]    pay_wa;
   logic [7:0]          pay_wd;

   logic [SEQ_BITS-1:0] ack_off;
   logic [IDX_W-1:0]    ack_idx;
   logic [IDX_W-1:0]    tail_idx;
   logic [TW-1:0]       idle_nx;
   logic [CNT_W-1:0]    unacked;
   logic [SEQ_BITS-1:0] resend_seq;
   logic [SEQ_BITS-1:0] send_seq;

   function automatic logic [IDX_W-1:0] wrap_idx(input logic [IDX_W:0] sum);
      logic [IDX_W:0] red;
      red = (sum >= (IDX_W + 1)'(WINDOW)) ? sum - (IDX_W + 1)'(WINDOW) : sum;
      return red[IDX_W-1:0];
   endfunction

   assign ack_off    = SEQ_BITS'(req_data.ack_seq) - base_ff;
   assign ack_idx    = wrap_idx({1'b0, head_ff} + (IDX_W + 1)'(ack_off));
   assign tail_idx   = wrap_idx({1'b0, head_ff} + (IDX_W + 1)'(cnt_ff));
   assign idle_nx    = (idle_ff == {TW{1'b1}}) ? idle_ff : idle_ff + TW'(1);
   assign unacked    = cnt_ff - ackc_ff;
   assign resend_seq = base_ff + SEQ_BITS'(off_ff);
   assign send_seq   = base_ff + SEQ_BITS'(cnt_ff);

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

   always_comb begin
      state_in     = state_ff;
      base_in      = base_ff;
      head_in      = head_ff;
      cnt_in       = cnt_ff;
      ackc_in      = ackc_ff;
      mark_in      = mark_ff;
      idle_in      = idle_ff;
      ptr_in       = ptr_ff;
      off_in       = off_ff;
      rem_in       = rem_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      pay_we       = 1'b0;
      pay_wa       = tail_idx;
      pay_wd       = req_data.payload;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (req_data.opcode)
                  gbns_pkg::OP_PAYLOAD: begin
                     rsp_valid_in     = 1'b1;
                     rsp_in.last      = 1'b1;
                     rsp_in.in_flight = 5'(cnt_ff);
                     if (cnt_ff < CNT_W'(WINDOW)) begin
                        pay_we            = 1'b1;
                        mark_in[tail_idx] = 1'b0;
                        cnt_in            = cnt_ff + CNT_W'(1);
                        idle_in           = '0;
                        rsp_in.send_valid = 1'b1;
                        rsp_in.send_seq   = 8'(send_seq);
                        rsp_in.send_byte  = req_data.payload;
                        rsp_in.accepted   = 1'b1;
                        rsp_in.in_flight  = 5'(cnt_ff + CNT_W'(1));
                     end
                  end
                  gbns_pkg::OP_ACK: begin
                     if (ack_off < SEQ_BITS'(cnt_ff)) begin
                        idle_in = '0;
                        if (!mark_ff[ack_idx]) begin
                           mark_in[ack_idx] = 1'b1;
                           ackc_in          = ackc_ff + CNT_W'(1);
                        end
                        state_in = ST_SLIDE;
                     end else begin
                        rsp_valid_in     = 1'b1;
                        rsp_in.last      = 1'b1;
                        rsp_in.in_flight = 5'(cnt_ff);
                     end
                  end
                  gbns_pkg::OP_TICK: begin
                     if (idle_nx >= timeout_ff) begin
                        idle_in = '0;
                        if (unacked == '0) begin
                           rsp_valid_in     = 1'b1;
                           rsp_in.last      = 1'b1;
                           rsp_in.in_flight = 5'(cnt_ff);
                        end else begin
                           rem_in   = unacked;
                           ptr_in   = head_ff;
                           off_in   = '0;
                           state_in = ST_RESEND;
                        end
                     end else begin
                        idle_in          = idle_nx;
                        rsp_valid_in     = 1'b1;
                        rsp_in.last      = 1'b1;
                        rsp_in.in_flight = 5'(cnt_ff);
                     end
                  end
                  default: begin
                     rsp_valid_in     = 1'b1;
                     rsp_in.last      = 1'b1;
                     rsp_in.in_flight = 5'(cnt_ff);
                  end
               endcase
            end
         end
         ST_SLIDE: begin
            if ((cnt_ff != '0) && mark_ff[head_ff]) begin
               mark_in[head_ff] = 1'b0;
               head_in          = wrap_idx({1'b0, head_ff} + (IDX_W + 1)'(1));
               base_in          = base_ff + SEQ_BITS'(1);
               cnt_in           = cnt_ff - CNT_W'(1);
               ackc_in          = ackc_ff - CNT_W'(1);
            end else begin
               rsp_valid_in     = 1'b1;
               rsp_in.last      = 1'b1;
               rsp_in.in_flight = 5'(cnt_ff);
               state_in         = ST_IDLE;
            end
         end
         ST_RESEND: begin
            if (!mark_ff[ptr_ff]) begin
               rsp_valid_in      = 1'b1;
               rsp_in.send_valid = 1'b1;
               rsp_in.send_seq   = 8'(resend_seq);
               rsp_in.send_byte  = pay_ff[ptr_ff];
               rsp_in.is_resend  = 1'b1;
               rsp_in.in_flight  = 5'(cnt_ff);
               rsp_in.last       = (rem_ff == CNT_W'(1));
               rem_in            = rem_ff - CNT_W'(1);
               if (rem_ff == CNT_W'(1)) begin
                  state_in = ST_IDLE;
               end
            end
            ptr_in = wrap_idx({1'b0, ptr_ff} + (IDX_W + 1)'(1));
            off_in = off_ff + CNT_W'(1);
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         base_ff      <= '0;
         head_ff      <= '0;
         cnt_ff       <= '0;
         ackc_ff      <= '0;
         mark_ff      <= '0;
         idle_ff      <= '0;
         timeout_ff   <= gbns_pkg::TIMEOUT_RESET;
         ptr_ff       <= '0;
         off_ff       <= '0;
         rem_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         base_ff      <= base_in;
         head_ff      <= head_in;
         cnt_ff       <= cnt_in;
         ackc_ff      <= ackc_in;
         mark_ff      <= mark_in;
         idle_ff      <= idle_in;
         ptr_ff       <= ptr_in;
         off_ff       <= off_in;
         rem_ff       <= rem_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            timeout_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (pay_we) begin
         pay_ff[pay_wa] <= pay_wd;
      end
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(WINDOW))
      else $error("outstanding count exceeds window");

   a_ackc_bound: assert property (@(posedge clock) disable iff (reset)
      ackc_ff <= cnt_ff)
      else $error("acked count exceeds outstanding count");

   a_resend_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.is_resend |-> rsp_data.send_valid && !rsp_data.accepted)
      else $error("resend result malformed");

   a_start_progress: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> rsp_valid || busy)
      else $error("accepted transaction produced no activity");

endmodule
